>>> rtl/rpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpr_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int NUM_W       = SAMPLE_BITS + 1;
    localparam int REM_W       = SAMPLE_BITS + 8;
    localparam int Q_BITS      = 7;
    localparam int QCNT_W      = $clog2(Q_BITS);
    localparam int PCT_SCALE   = 200;

    localparam logic [7:0] SOF_BYTE      = 8'hAA;
    localparam logic [7:0] PING_OP       = 8'h01;
    localparam logic [7:0] PONG_OP       = 8'h02;
    localparam logic [7:0] PONG_LEN      = 8'h01;
    localparam logic [7:0] PCT_FULL      = 8'd100;
    localparam logic [SAMPLE_BITS-1:0] DRY_RESET = SAMPLE_BITS'(3000);
    localparam logic [SAMPLE_BITS-1:0] WET_RESET = SAMPLE_BITS'(1000);
    localparam logic [7:0] OWN_RESET     = 8'h01;

    localparam logic [2:0] TX_SOF    = 3'd0;
    localparam logic [2:0] TX_ADDR   = 3'd1;
    localparam logic [2:0] TX_CMD    = 3'd2;
    localparam logic [2:0] TX_LEN    = 3'd3;
    localparam logic [2:0] TX_PCT    = 3'd4;
    localparam logic [2:0] TX_SUM    = 3'd5;

    localparam logic [1:0] REG_OWN_ADDR = 2'd0;
    localparam logic [1:0] REG_DRY      = 2'd1;
    localparam logic [1:0] REG_WET      = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_ADDR = 3'd1,
        PH_CMD  = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_SUM  = 3'd5
    } parse_phase_t;

    typedef enum logic [1:0] {
        ST_RECV = 2'd0,
        ST_PREP = 2'd1,
        ST_DIV  = 2'd2,
        ST_SEND = 2'd3
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic send_adv;
    } ctl_cmd_t;

    typedef struct packed {
        logic ping_hit;
        logic div_last;
        logic send_last;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/rpr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rpr_in_if import rpr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [7:0]             rx_byte;
    logic [SAMPLE_BITS-1:0] adc_raw;

    modport source (output valid, output rx_byte, output adc_raw, input ready);
    modport sink   (input valid, input rx_byte, input adc_raw, output ready);
endinterface

interface rpr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, output tx_byte, output last_byte, input ready);
    modport sink   (input valid, input tx_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/rpr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rpr_ctrl import rpr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic     out_ready,
    output logic          out_valid,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RECV:
            begin
                if (in_valid && stat.ping_hit)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_ready && stat.send_last)
                begin
                    state_next = ST_RECV;
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_RECV:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_PREP:
            begin
                cmd.load = 1'b1;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_SEND:
            begin
                out_valid    = 1'b1;
                cmd.send_adv = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/rpr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rpr_datapath import rpr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ctl_cmd_t               cmd,
    output dp_stat_t                    stat,
    input  wire logic [7:0]             own_address,
    input  wire logic [SAMPLE_BITS-1:0] dry_level,
    input  wire logic [SAMPLE_BITS-1:0] wet_level,
    input  wire logic [7:0]             rx_byte,
    input  wire logic [SAMPLE_BITS-1:0] adc_raw,
    output logic [7:0]                  tx_byte,
    output logic                        last_byte
);

    // frame parser
    parse_phase_t phase_reg, phase_next;
    logic [7:0]   addr_reg, addr_next;
    logic [7:0]   cmd_reg, cmd_next;
    logic [7:0]   left_reg, left_next;
    logic [7:0]   sum_reg, sum_next;
    logic [7:0]   left_dec;

    // percent divider
    logic [SAMPLE_BITS-1:0] raw_reg;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [REM_W-1:0]       div_reg, div_next;
    logic [Q_BITS-1:0]      q_reg, q_next;
    logic [QCNT_W-1:0]      cnt_reg, cnt_next;
    logic                   zero_reg, zero_next;
    logic                   full_reg, full_next;
    logic [2:0]             idx_reg, idx_next;

    logic signed [NUM_W-1:0] num_s, den_s, num_a, den_a;
    logic                    pct_zero, pct_full;
    logic [REM_W-1:0]        rem_init, div_init;
    logic [7:0]              pct;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            addr_reg  <= '0;
            cmd_reg   <= '0;
            left_reg  <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            cmd_reg   <= cmd_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            raw_reg <= adc_raw;
        end
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        q_reg    <= q_next;
        zero_reg <= zero_next;
        full_reg <= full_next;
    end

    assign left_dec = left_reg - 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        cmd_next   = cmd_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        if (cmd.accept)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SOF_BYTE)
                    begin
                        sum_next   = '0;
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    addr_next  = rx_byte;
                    sum_next   = rx_byte;
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    left_next  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
                end
                PH_DATA:
                begin
                    sum_next  = sum_reg + rx_byte;
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    phase_next = PH_HUNT;
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // num and den folded to den > 0; percent = floor((200*num + den) / (2*den))
    always_comb
    begin
        num_s = $signed({1'b0, dry_level}) - $signed({1'b0, raw_reg});
        den_s = $signed({1'b0, dry_level}) - $signed({1'b0, wet_level});
        if (den_s[NUM_W-1])
        begin
            num_a = -num_s;
            den_a = -den_s;
        end
        else
        begin
            num_a = num_s;
            den_a = den_s;
        end
        pct_zero = (den_a == '0) || num_a[NUM_W-1] || (num_a == '0);
        pct_full = !pct_zero && (num_a >= den_a);
        rem_init = ({8'b0, num_a[SAMPLE_BITS-1:0]} * REM_W'(PCT_SCALE))
                   + {8'b0, den_a[SAMPLE_BITS-1:0]};
        div_init = {1'b0, den_a[SAMPLE_BITS-1:0], 1'b0, {(Q_BITS-1){1'b0}}};
    end

    always_comb
    begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        zero_next = zero_reg;
        full_next = full_reg;
        idx_next  = idx_reg;
        if (cmd.load)
        begin
            rem_next  = rem_init;
            div_next  = div_init;
            q_next    = '0;
            cnt_next  = '0;
            zero_next = pct_zero;
            full_next = pct_full;
            idx_next  = TX_SOF;
        end
        if (cmd.step)
        begin
            if (rem_reg >= div_reg)
            begin
                rem_next = rem_reg - div_reg;
                q_next   = {q_reg[Q_BITS-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[Q_BITS-2:0], 1'b0};
            end
            div_next = div_reg >> 1;
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        if (cmd.send_adv)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    assign pct = zero_reg ? 8'd0 : (full_reg ? PCT_FULL : {{(8-Q_BITS){1'b0}}, q_reg});

    always_comb
    begin
        case (idx_reg)
            TX_SOF:  tx_byte = SOF_BYTE;
            TX_ADDR: tx_byte = own_address;
            TX_CMD:  tx_byte = PONG_OP;
            TX_LEN:  tx_byte = PONG_LEN;
            TX_PCT:  tx_byte = pct;
            TX_SUM:  tx_byte = own_address + PONG_OP + PONG_LEN + pct;
            default: tx_byte = 8'd0;
        endcase
    end

    assign last_byte = (idx_reg == TX_SUM);

    assign stat.ping_hit  = (phase_reg == PH_SUM) && (rx_byte == sum_reg)
                            && (addr_reg == own_address) && (cmd_reg == PING_OP);
    assign stat.div_last  = (cnt_reg == QCNT_W'(Q_BITS - 1));
    assign stat.send_last = (idx_reg == TX_SUM);

endmodule

`default_nettype wire

>>> rtl/rs485_ping_responder.sv
`timescale 1ns / 1ps
`default_nettype none

// A received word is taken while the responder waits for input; one that is not a checksum
// of a matching ping leaves no result. A matching checksum word is followed by
// a setup step and the restoring percent divider, then six pong
// words, one per cycle while the sink is ready. No word is taken meanwhile.
// Reset: parser hunts for the start byte, own_address=1, dry=3000, wet=1000.
module rs485_ping_responder import rpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    rpr_in_if.sink           in_ch,
    rpr_out_if.source        out_ch
);

    logic [7:0]             own_reg;
    logic [SAMPLE_BITS-1:0] dry_reg;
    logic [SAMPLE_BITS-1:0] wet_reg;
    logic                   wr_en;
    ctl_cmd_t               cmd;
    dp_stat_t               stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg <= OWN_RESET;
            dry_reg <= DRY_RESET;
            wet_reg <= WET_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_OWN_ADDR: own_reg <= pwdata[7:0];
                REG_DRY:      dry_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_WET:      wet_reg <= pwdata[SAMPLE_BITS-1:0];
                default:      own_reg <= own_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_OWN_ADDR: prdata = {24'b0, own_reg};
            REG_DRY:      prdata = {{(32-SAMPLE_BITS){1'b0}}, dry_reg};
            REG_WET:      prdata = {{(32-SAMPLE_BITS){1'b0}}, wet_reg};
            default:      prdata = 32'b0;
        endcase
    end

    rpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    rpr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .own_address (own_reg),
        .dry_level   (dry_reg),
        .wet_level   (wet_reg),
        .rx_byte     (in_ch.rx_byte),
        .adc_raw     (in_ch.adc_raw),
        .tx_byte     (out_ch.tx_byte),
        .last_byte   (out_ch.last_byte)
    );

endmodule

`default_nettype wire
